/* design/scjc_pkg.sv */
// Shared types, constants and byte-generation functions for the serial camera capture block.
`default_nettype none
package scjc_pkg;

	localparam int unsigned LEN_REPLY_BYTES_DEF = 9;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam logic [15:0] MIN_END_OFFSET_RST = 16'd1000;

	// Input operation codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_BYTE  = 1'b1;

	// Job kinds handed from the front to the back
	localparam logic [2:0] JOB_CLEAR  = 3'd0;
	localparam logic [2:0] JOB_TAKE   = 3'd1;
	localparam logic [2:0] JOB_GETLEN = 3'd2;
	localparam logic [2:0] JOB_READ   = 3'd3;
	localparam logic [2:0] JOB_IMG    = 3'd4;
	localparam logic [2:0] JOB_HEAD   = 3'd5;
	localparam logic [2:0] JOB_END    = 3'd6;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] data;
	} scjc_job_t;

	typedef struct packed {
		logic       channel;
		logic [7:0] out_byte;
		logic       end_of_run;
	} scjc_word_t;

	// Index of the last word a job produces
	function automatic logic [3:0] job_last_idx(input logic [2:0] kind);
		logic [3:0] r;
		unique case (kind)
			JOB_CLEAR, JOB_TAKE, JOB_GETLEN, JOB_END: r = 4'd4;
			JOB_READ: r = 4'd15;
			JOB_HEAD: r = 4'd1;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	// Word number idx of a job
	function automatic scjc_word_t job_word(input logic [2:0] kind, input logic [15:0] data,
			input logic [3:0] idx);
		scjc_word_t w;
		w = '0;
		unique case (kind)
			JOB_CLEAR, JOB_TAKE, JOB_GETLEN: begin
				w.channel = 1'b0;
				w.end_of_run = (idx == 4'd4);
				unique case (idx)
					4'd0: w.out_byte = 8'h56;
					4'd2: w.out_byte = (kind == JOB_GETLEN) ? 8'h34 : 8'h36;
					4'd3: w.out_byte = 8'h01;
					4'd4: w.out_byte = (kind == JOB_CLEAR) ? 8'h03 : 8'h00;
					default: w.out_byte = 8'h00;
				endcase
			end
			JOB_READ: begin
				w.channel = 1'b0;
				w.end_of_run = (idx == 4'd15);
				unique case (idx)
					4'd0: w.out_byte = 8'h56;
					4'd2: w.out_byte = 8'h32;
					4'd3: w.out_byte = 8'h0C;
					4'd5: w.out_byte = 8'h0A;
					4'd12: w.out_byte = data[15:8];
					4'd13: w.out_byte = data[7:0];
					4'd15: w.out_byte = 8'hFF;
					default: w.out_byte = 8'h00;
				endcase
			end
			JOB_IMG: begin
				w.channel = 1'b1;
				w.out_byte = data[7:0];
				w.end_of_run = 1'b0;
			end
			JOB_HEAD: begin
				w.channel = 1'b1;
				w.out_byte = (idx == 4'd0) ? 8'hFF : 8'hD8;
				w.end_of_run = 1'b0;
			end
			JOB_END: begin
				// image end byte, then the reset command
				w.channel = (idx == 4'd0);
				w.end_of_run = (idx == 4'd0) || (idx == 4'd4);
				unique case (idx)
					4'd0: w.out_byte = 8'hD9;
					4'd1: w.out_byte = 8'h56;
					4'd3: w.out_byte = 8'h26;
					default: w.out_byte = 8'h00;
				endcase
			end
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

/* design/scjc_front.sv */
// Front part: accepts input words, tracks the capture sequence and posts jobs.
`default_nettype none
module scjc_front import scjc_pkg::*; #(
	parameter int unsigned LEN_REPLY_BYTES = LEN_REPLY_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        chunk_last,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        q_full,
	output logic             push,
	output scjc_job_t        push_job
);

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_CLEAN  = 3'd1;
	localparam logic [2:0] MODE_TAKE   = 3'd2;
	localparam logic [2:0] MODE_GETLEN = 3'd3;
	localparam logic [2:0] MODE_SAVE   = 3'd4;

	logic [2:0]  mode_q, mode_d;
	logic [3:0]  resp_count_q, resp_count_d;
	logic [15:0] byte_offset_q, byte_offset_d;
	logic        head_found_q, head_found_d;
	logic        prev_ff_q, prev_ff_d;
	logic [15:0] min_end_offset_q;
	logic [7:0]  resp_q [LEN_REPLY_BYTES];
	logic [7:0]  resp_view [LEN_REPLY_BYTES];
	logic        accept, resp_wr, is_ack, in_reply;
	logic [3:0]  count_inc;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;
	assign in_reply = (mode_q == MODE_CLEAN) || (mode_q == MODE_TAKE) ||
		(mode_q == MODE_GETLEN);
	assign resp_wr = accept && (op != OP_START) && in_reply &&
		(resp_count_q < 4'(LEN_REPLY_BYTES));
	assign count_inc = (resp_count_q != 4'hF) ? resp_count_q + 4'd1 : resp_count_q;

	// Reply bytes as they stand after this word is stored
	always_comb begin
		for (int i = 0; i < LEN_REPLY_BYTES; i++) begin
			resp_view[i] = (resp_wr && resp_count_q == 4'(i)) ? rx_byte : resp_q[i];
		end
	end

	assign is_ack = (count_inc == 4'd5) && resp_view[0] == 8'h76 && resp_view[1] == 8'h00 &&
		resp_view[2] == 8'h36 && resp_view[3] == 8'h00 && resp_view[4] == 8'h00;

	always_comb begin
		mode_d = mode_q;
		resp_count_d = resp_count_q;
		byte_offset_d = byte_offset_q;
		head_found_d = head_found_q;
		prev_ff_d = prev_ff_q;
		push = 1'b0;
		push_job = '{kind: JOB_IMG, data: {8'h00, rx_byte}};
		if (accept) begin
			if (op == OP_START) begin
				mode_d = MODE_CLEAN;
				resp_count_d = '0;
				head_found_d = 1'b0;
				prev_ff_d = 1'b0;
				push = 1'b1;
				push_job.kind = JOB_CLEAR;
			end else if (mode_q == MODE_SAVE) begin
				if (byte_offset_q != 16'hFFFF) byte_offset_d = byte_offset_q + 16'd1;
				prev_ff_d = (rx_byte == 8'hFF);
				if (!head_found_q) begin
					if (prev_ff_q && rx_byte == 8'hD8) begin
						head_found_d = 1'b1;
						push = 1'b1;
						push_job.kind = JOB_HEAD;
					end
				end else if (prev_ff_q && rx_byte == 8'hD9 &&
						byte_offset_q > min_end_offset_q) begin
					mode_d = MODE_IDLE;
					resp_count_d = '0;
					head_found_d = 1'b0;
					prev_ff_d = 1'b0;
					push = 1'b1;
					push_job.kind = JOB_END;
				end else begin
					push = 1'b1;
				end
			end else if (in_reply) begin
				resp_count_d = count_inc;
				if (chunk_last) begin
					if (mode_q == MODE_CLEAN && is_ack) begin
						resp_count_d = '0;
						mode_d = MODE_TAKE;
						push = 1'b1;
						push_job.kind = JOB_TAKE;
					end else if (mode_q == MODE_TAKE && is_ack) begin
						resp_count_d = '0;
						mode_d = MODE_GETLEN;
						push = 1'b1;
						push_job.kind = JOB_GETLEN;
					end else if (mode_q == MODE_GETLEN &&
							count_inc == 4'(LEN_REPLY_BYTES)) begin
						resp_count_d = '0;
						byte_offset_d = '0;
						head_found_d = 1'b0;
						prev_ff_d = 1'b0;
						mode_d = MODE_SAVE;
						push = 1'b1;
						push_job.kind = JOB_READ;
						push_job.data = {resp_view[LEN_REPLY_BYTES-2],
							resp_view[LEN_REPLY_BYTES-1]};
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			resp_count_q <= '0;
			byte_offset_q <= '0;
			head_found_q <= 1'b0;
			prev_ff_q <= 1'b0;
			min_end_offset_q <= MIN_END_OFFSET_RST;
		end else begin
			mode_q <= mode_d;
			resp_count_q <= resp_count_d;
			byte_offset_q <= byte_offset_d;
			head_found_q <= head_found_d;
			prev_ff_q <= prev_ff_d;
			if (cfg_wr_en) min_end_offset_q <= cfg_wr_data;
		end
	end

	// reply store: entries are read only after they are written
	always_ff @(posedge clk) begin
		for (int i = 0; i < LEN_REPLY_BYTES; i++) begin
			if (resp_wr && resp_count_q == 4'(i)) resp_q[i] <= rx_byte;
		end
	end

endmodule
`default_nettype wire

/* design/scjc_queue.sv */
// Short job queue between the front and back parts.
`default_nettype none
module scjc_queue import scjc_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire scjc_job_t push_job,
	output logic           full,
	input  wire logic      pop,
	output logic           head_valid,
	output scjc_job_t      head_job
);

	localparam int unsigned PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNTW = $clog2(DEPTH + 1);

	scjc_job_t       mem_q [DEPTH];
	logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic            do_push, do_pop;

	assign full = (count_q == CNTW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + PTRW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + PTRW'(1);
			end
			if (do_push && !do_pop) count_q <= count_q + CNTW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_job;
	end

endmodule
`default_nettype wire

/* design/scjc_back.sv */
// Back part: expands queued jobs into output words through an output register.
`default_nettype none
module scjc_back import scjc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       head_valid,
	input  wire scjc_job_t  head_job,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            channel,
	output logic [7:0]      out_byte,
	output logic            end_of_run
);

	logic [3:0]  idx_q;
	logic        out_valid_q, load, at_last;
	scjc_word_t  word, word_q;

	assign word = job_word(head_job.kind, head_job.data, idx_q);
	assign at_last = (idx_q == job_last_idx(head_job.kind));
	assign load = head_valid && (!out_valid_q || !out_stall);
	assign pop = load && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || !out_stall) out_valid_q <= head_valid;
			if (load) idx_q <= at_last ? '0 : idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) word_q <= word;
	end

	assign out_valid = out_valid_q;
	assign channel = word_q.channel;
	assign out_byte = word_q.out_byte;
	assign end_of_run = word_q.end_of_run;

endmodule
`default_nettype wire

/* design/serial_camera_jpeg_capture.sv */
// Top level of the serial camera capture controller.
// Usage:
//  - Input channel (in_valid/in_stall): op 0 starts a capture (aborting any run),
//    op 1 carries a byte received from the camera; chunk_last marks a chunk end,
//    where replies are checked against the expected acknowledgement.
//  - Output channel (out_valid/out_stall): a word per cycle while not stalled, either a command
//    byte for the camera (channel 0) or an image byte (channel 1); end_of_run
//    flags the last byte of each command and the image end byte.
//  - cfg_wr_en/cfg_wr_data write min_end_offset (reset 1000); write only while idle.
// Timing: the front takes one input word per cycle unless the queue is full, and posts
// at most one job into a four-entry queue; the back drains one output word per cycle
// when the receiver does not stall. The first word of a job passes through the queue
// and then the output register before it is presented. A job yields 1 to 16 words
// (16 for the read command), so output bandwidth of one word per cycle sets how fast
// bursts drain; the front stalls only when the queue is full.
// Reset: idle, counters cleared, queue and output register empty.
// Receiver stall: hold the output word; the queue keeps taking inputs until full.
`default_nettype none
module serial_camera_jpeg_capture import scjc_pkg::*; #(
	parameter int unsigned LEN_REPLY_BYTES = LEN_REPLY_BYTES_DEF,
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        chunk_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             channel,
	output logic [7:0]       out_byte,
	output logic             end_of_run,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data
);

	logic      push, q_full, pop, head_valid;
	scjc_job_t push_job, head_job;

	// Front: classify each word and advance the capture sequence
	scjc_front #(.LEN_REPLY_BYTES(LEN_REPLY_BYTES)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .op, .rx_byte, .chunk_last,
		.cfg_wr_en, .cfg_wr_data, .q_full, .push, .push_job
	);

	// Queue: decouple input acceptance from command bursts
	scjc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .push, .push_job, .full(q_full), .pop, .head_valid, .head_job
	);

	// Back: emit the words of each job in order
	scjc_back u_back (
		.clk, .arst_n, .head_valid, .head_job, .pop, .out_valid, .out_stall,
		.channel, .out_byte, .end_of_run
	);

endmodule
`default_nettype wire
